// File: src/vau_pkg.sv
// ----------------------------------------------------------------------------
// vau_pkg
// Shared types, opcodes and helper functions of the 3D vector arithmetic unit.
// ----------------------------------------------------------------------------
package vau_pkg;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_NEG    = 4'd2,
    OP_MUL    = 4'd3,
    OP_SCALE  = 4'd4,
    OP_DIV    = 4'd5,
    OP_DOT    = 4'd6,
    OP_CROSS  = 4'd7,
    OP_SQRLEN = 4'd8,
    OP_LEN    = 4'd9,
    OP_NORM   = 4'd10,
    OP_EQ     = 4'd11,
    OP_NE     = 4'd12,
    OP_GT     = 4'd13,
    OP_LT     = 4'd14
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               is_long;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] s;
  } item_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] sc;
    logic               flag;
    logic               ov;
  } res_t;

  localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN32 = 32'h8000_0000;

  function automatic logic signed [66:0] ext32(input logic signed [31:0] v);
    ext32 = {{35{v[31]}}, v};
  endfunction

  function automatic logic signed [66:0] ext64(input logic signed [63:0] v);
    ext64 = {{3{v[63]}}, v};
  endfunction

  // Clamp to the 32-bit signed range; bit 32 of the result is the overflow.
  function automatic logic [32:0] sat67(input logic signed [66:0] v);
    if (v > 67'sd2147483647) begin
      sat67 = {1'b1, MAX32};
    end else if (v < -67'sd2147483648) begin
      sat67 = {1'b1, MIN32};
    end else begin
      sat67 = {1'b0, v[31:0]};
    end
  endfunction

endpackage

// File: src/vau_front.sv
// ----------------------------------------------------------------------------
// vau_front
// Accepts commands, tags the ones that need the iterative unit, and holds
// them in a two-entry queue in front of the execution pipeline.
// ----------------------------------------------------------------------------
module vau_front import vau_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_op,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  input  logic signed [31:0] in_scalar_in,
  input  logic               adv,
  output logic               pop,
  output item_t              head
);

  item_t       q_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push;
  item_t       itm;

  always_comb begin
    itm.op      = op_t'(in_op);
    itm.is_long = (itm.op == OP_DIV) || (itm.op == OP_LEN) || (itm.op == OP_NORM);
    itm.a_x     = in_a_x;
    itm.a_y     = in_a_y;
    itm.a_z     = in_a_z;
    itm.b_x     = in_b_x;
    itm.b_y     = in_b_y;
    itm.b_z     = in_b_z;
    itm.s       = in_scalar_in;
  end

  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy;
  assign pop  = adv && (cnt_r != 2'd0);
  assign head = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= itm;
    end
  end

endmodule

// File: src/vau_pipe.sv
// ----------------------------------------------------------------------------
// vau_pipe
// Operand register, six-multiplier product stage and a final stage that
// sums, rounds and saturates. Long operations are handed off at the end.
// ----------------------------------------------------------------------------
module vau_pipe import vau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_v,
  input  item_t       in_item,
  output logic        c_valid,
  output logic        c_long,
  output item_t       c_item,
  output logic [63:0] c_sq,
  output res_t        c_res
);

  localparam logic signed [66:0] HALF = 67'sd1 <<< (FRAC_BITS - 1);

  logic               s1_v_r, s2_v_r;
  item_t              s1_r, s2_r;
  logic signed [63:0] p_r [3];
  logic signed [63:0] q_r [3];
  logic signed [31:0] ma [3], mb [3], qa [3], qb [3];
  logic signed [63:0] pn [3], qn [3];

  function automatic logic signed [66:0] rnd(input logic signed [66:0] v);
    rnd = (v + HALF) >>> FRAC_BITS;
  endfunction

  // Multiplier operand selection.
  always_comb begin
    qa[0] = s1_r.a_z; qb[0] = s1_r.b_y;
    qa[1] = s1_r.a_x; qb[1] = s1_r.b_z;
    qa[2] = s1_r.a_y; qb[2] = s1_r.b_x;
    ma[0] = s1_r.a_x; ma[1] = s1_r.a_y; ma[2] = s1_r.a_z;
    mb[0] = s1_r.b_x; mb[1] = s1_r.b_y; mb[2] = s1_r.b_z;
    unique case (s1_r.op) inside
      OP_SCALE: begin
        mb[0] = s1_r.s; mb[1] = s1_r.s; mb[2] = s1_r.s;
      end
      OP_SQRLEN, OP_LEN, OP_NORM: begin
        mb[0] = s1_r.a_x; mb[1] = s1_r.a_y; mb[2] = s1_r.a_z;
      end
      OP_CROSS: begin
        ma[0] = s1_r.a_y; mb[0] = s1_r.b_z;
        ma[1] = s1_r.a_z; mb[1] = s1_r.b_x;
        ma[2] = s1_r.a_x; mb[2] = s1_r.b_y;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      pn[i] = ma[i] * mb[i];
      qn[i] = qa[i] * qb[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_v;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= in_item;
      s2_r <= s1_r;
      for (int i = 0; i < 3; i++) begin
        p_r[i] <= pn[i];
        q_r[i] <= qn[i];
      end
    end
  end

  // Final stage: rounding, saturation and result selection.
  logic signed [31:0] av [3], bv [3];
  logic [32:0]        sadd [3], ssub [3], sneg [3], smul [3], scr [3];
  logic [32:0]        sdot;
  logic               div_zero;

  always_comb begin
    av[0] = s2_r.a_x; av[1] = s2_r.a_y; av[2] = s2_r.a_z;
    bv[0] = s2_r.b_x; bv[1] = s2_r.b_y; bv[2] = s2_r.b_z;
    for (int i = 0; i < 3; i++) begin
      sadd[i] = sat67(ext32(av[i]) + ext32(bv[i]));
      ssub[i] = sat67(ext32(av[i]) - ext32(bv[i]));
      sneg[i] = sat67(-ext32(av[i]));
      smul[i] = sat67(rnd(ext64(p_r[i])));
      scr[i]  = sat67(rnd(ext64(p_r[i]) - ext64(q_r[i])));
    end
    sdot     = sat67(rnd(ext64(p_r[0]) + ext64(p_r[1]) + ext64(p_r[2])));
    c_sq     = p_r[0][63:0] + p_r[1][63:0] + p_r[2][63:0];
    div_zero = (s2_r.op == OP_DIV) && (s2_r.s == 32'sd0);

    c_res = '0;
    unique case (s2_r.op) inside
      OP_ADD: begin
        c_res.r_x = sadd[0][31:0]; c_res.r_y = sadd[1][31:0]; c_res.r_z = sadd[2][31:0];
        c_res.ov  = sadd[0][32] | sadd[1][32] | sadd[2][32];
      end
      OP_SUB: begin
        c_res.r_x = ssub[0][31:0]; c_res.r_y = ssub[1][31:0]; c_res.r_z = ssub[2][31:0];
        c_res.ov  = ssub[0][32] | ssub[1][32] | ssub[2][32];
      end
      OP_NEG: begin
        c_res.r_x = sneg[0][31:0]; c_res.r_y = sneg[1][31:0]; c_res.r_z = sneg[2][31:0];
        c_res.ov  = sneg[0][32] | sneg[1][32] | sneg[2][32];
      end
      OP_MUL, OP_SCALE: begin
        c_res.r_x = smul[0][31:0]; c_res.r_y = smul[1][31:0]; c_res.r_z = smul[2][31:0];
        c_res.ov  = smul[0][32] | smul[1][32] | smul[2][32];
      end
      OP_CROSS: begin
        c_res.r_x = scr[0][31:0]; c_res.r_y = scr[1][31:0]; c_res.r_z = scr[2][31:0];
        c_res.ov  = scr[0][32] | scr[1][32] | scr[2][32];
      end
      OP_DOT, OP_SQRLEN: begin
        c_res.sc = sdot[31:0];
        c_res.ov = sdot[32];
      end
      OP_DIV: begin
        // Only the zero divisor is finished here; it saturates by sign, zero stays zero.
        c_res.r_x = (av[0] > 0) ? MAX32 : ((av[0] < 0) ? MIN32 : 32'd0);
        c_res.r_y = (av[1] > 0) ? MAX32 : ((av[1] < 0) ? MIN32 : 32'd0);
        c_res.r_z = (av[2] > 0) ? MAX32 : ((av[2] < 0) ? MIN32 : 32'd0);
        c_res.ov  = 1'b1;
      end
      OP_EQ: c_res.flag = (av[0] == bv[0]) && (av[1] == bv[1]) && (av[2] == bv[2]);
      OP_NE: c_res.flag = !((av[0] == bv[0]) && (av[1] == bv[1]) && (av[2] == bv[2]));
      OP_GT: c_res.flag = (av[0] > bv[0]) && (av[1] > bv[1]) && (av[2] > bv[2]);
      OP_LT: c_res.flag = (av[0] < bv[0]) && (av[1] < bv[1]) && (av[2] < bv[2]);
      default: begin
      end
    endcase
  end

  assign c_valid = s2_v_r;
  assign c_long  = s2_r.is_long && !div_zero;
  assign c_item  = s2_r;

endmodule

// File: src/vau_iter.sv
// ----------------------------------------------------------------------------
// vau_iter
// Iterative unit: bit-serial square root with rounding and a three-lane
// restoring divider, one quotient bit per lane and cycle.
// ----------------------------------------------------------------------------
module vau_iter import vau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  item_t       item,
  input  logic [63:0] sq,
  output logic        busy,
  output logic        done,
  output res_t        res
);

  localparam int NUMW = 32 + FRAC_BITS + 1;
  localparam int CW   = $clog2(NUMW + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQRT, ST_SQFIN, ST_DIV, ST_DIVFIN, ST_DONE
  } state_t;

  state_t             state_r;
  op_t                op_r;
  logic signed [31:0] a_r [3];
  logic [NUMW-1:0]    num_r [3];
  logic [31:0]        rem_r [3];
  logic [31:0]        d_r;
  logic               dneg_r;
  logic [CW-1:0]      cnt_r;
  logic [63:0]        n_r, rt_r, bit_r;
  res_t               res_r;

  logic [63:0]        rb;
  logic               sq_ge;
  logic [32:0]        t [3];
  logic               ge [3];
  logic [32:0]        len_nxt;

  function automatic logic [NUMW-1:0] num_init(input logic signed [31:0] a,
                                               input logic [31:0] d);
    logic [31:0] amag;
    amag = a[31] ? (32'd0 - a) : a;
    num_init = {1'b0, amag, {FRAC_BITS{1'b0}}} + NUMW'(d >> 1);
  endfunction

  // Signed, saturated quotient; bit 32 is the overflow.
  function automatic logic [32:0] q_fin(input logic [NUMW-1:0] q, input logic neg);
    if (neg) begin
      if (q > NUMW'(MIN32)) begin
        q_fin = {1'b1, MIN32};
      end else begin
        q_fin = {1'b0, 32'd0 - q[31:0]};
      end
    end else if (q > NUMW'(MAX32)) begin
      q_fin = {1'b1, MAX32};
    end else begin
      q_fin = {1'b0, q[31:0]};
    end
  endfunction

  always_comb begin
    rb      = rt_r + bit_r;
    sq_ge   = n_r >= rb;
    len_nxt = rt_r[32:0] + 33'(n_r > rt_r);
    for (int i = 0; i < 3; i++) begin
      t[i]  = {rem_r[i], num_r[i][NUMW-1]};
      ge[i] = t[i] >= {1'b0, d_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            op_r  <= item.op;
            a_r[0] <= item.a_x;
            a_r[1] <= item.a_y;
            a_r[2] <= item.a_z;
            res_r <= '0;
            if (item.op == OP_DIV) begin
              d_r    <= item.s[31] ? (32'd0 - item.s) : item.s;
              dneg_r <= item.s[31];
              num_r[0] <= num_init(item.a_x, item.s[31] ? (32'd0 - item.s) : item.s);
              num_r[1] <= num_init(item.a_y, item.s[31] ? (32'd0 - item.s) : item.s);
              num_r[2] <= num_init(item.a_z, item.s[31] ? (32'd0 - item.s) : item.s);
              for (int i = 0; i < 3; i++) rem_r[i] <= 32'd0;
              cnt_r   <= CW'(NUMW - 1);
              state_r <= ST_DIV;
            end else begin
              n_r     <= sq;
              rt_r    <= 64'd0;
              bit_r   <= 64'd1 << 62;
              state_r <= ST_SQRT;
            end
          end
        end
        ST_SQRT: begin
          if (sq_ge) begin
            n_r  <= n_r - rb;
            rt_r <= (rt_r >> 1) + bit_r;
          end else begin
            rt_r <= rt_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            state_r <= ST_SQFIN;
          end
        end
        ST_SQFIN: begin
          // A zero length also lands here with a length field of zero.
          if (len_nxt > {1'b0, MAX32}) begin
            res_r.sc <= MAX32;
            res_r.ov <= 1'b1;
          end else begin
            res_r.sc <= len_nxt[31:0];
          end
          if (op_r != OP_NORM) begin
            state_r <= ST_DONE;
          end else if (len_nxt == 33'd0) begin
            // Zero length hands A back unchanged.
            res_r.r_x <= a_r[0];
            res_r.r_y <= a_r[1];
            res_r.r_z <= a_r[2];
            state_r   <= ST_DONE;
          end else begin
            d_r    <= len_nxt[31:0];
            dneg_r <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              num_r[i] <= num_init(a_r[i], len_nxt[31:0]);
              rem_r[i] <= 32'd0;
            end
            cnt_r   <= CW'(NUMW - 1);
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          for (int i = 0; i < 3; i++) begin
            rem_r[i] <= ge[i] ? 32'(t[i] - {1'b0, d_r}) : t[i][31:0];
            num_r[i] <= {num_r[i][NUMW-2:0], ge[i]};
          end
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == CW'(0)) begin
            state_r <= ST_DIVFIN;
          end
        end
        ST_DIVFIN: begin
          logic [32:0] fx, fy, fz;
          fx = q_fin(num_r[0], a_r[0][31] ^ dneg_r);
          fy = q_fin(num_r[1], a_r[1][31] ^ dneg_r);
          fz = q_fin(num_r[2], a_r[2][31] ^ dneg_r);
          res_r.r_x <= fx[31:0];
          res_r.r_y <= fy[31:0];
          res_r.r_z <= fz[31:0];
          res_r.ov  <= res_r.ov | fx[32] | fy[32] | fz[32];
          state_r   <= ST_DONE;
        end
        ST_DONE: begin
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign done = (state_r == ST_DONE);
  assign res  = res_r;

endmodule

// File: src/vec3_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// vec3_arithmetic_unit
// 3D vector arithmetic on signed fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   --------------------   ---------------------------------------
//   command   start / busy           in_op, in_a_*, in_b_*, in_scalar_in
//   result    out_valid (strobe)     out_r_*, out_scalar_out, out_flag,
//                                    out_overflow
//
// A command transfers at a rising edge with start high and busy low. Add,
// subtract, negate, multiply, scale, dot, cross, squared length, compare and
// a divide by zero run in a three-stage pipeline at one transfer per cycle
// while the iterative unit is idle; a command passes the queue, the operand
// register, the product registers and the output register, whose strobe
// marks the result. Divide holds the pipeline for FRAC_BITS+33 quotient
// steps of one bit each plus finishing and done, length for 32 root steps
// of two radicand bits each plus finishing and done, and normalize for both
// in sequence; the pipeline holds while the iterative unit works, so
// results leave in command order. busy rises when the two-entry command
// queue is full. Reset (synchronous, rst_n low) empties queue and pipeline.
// The receiver cannot stall: out_valid marks each result for a single cycle.
//
module vec3_arithmetic_unit import vau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_op,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  input  logic signed [31:0] in_scalar_in,
  output logic               out_valid,
  output logic signed [31:0] out_r_x,
  output logic signed [31:0] out_r_y,
  output logic signed [31:0] out_r_z,
  output logic signed [31:0] out_scalar_out,
  output logic               out_flag,
  output logic               out_overflow
);

  logic        adv, pop;
  item_t       head;
  logic        c_valid, c_long;
  item_t       c_item;
  logic [63:0] c_sq;
  res_t        c_res;
  logic        it_busy, it_done;
  res_t        it_res;
  logic        short_ld, hand_off;
  logic        out_valid_r;
  res_t        out_r;

  // The pipeline moves only while the iterative unit is free.
  assign adv      = !it_busy;
  assign short_ld = adv && c_valid && !c_long;
  assign hand_off = adv && c_valid && c_long;

  vau_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_a_x       (in_a_x),
    .in_a_y       (in_a_y),
    .in_a_z       (in_a_z),
    .in_b_x       (in_b_x),
    .in_b_y       (in_b_y),
    .in_b_z       (in_b_z),
    .in_scalar_in (in_scalar_in),
    .adv          (adv),
    .pop          (pop),
    .head         (head)
  );

  vau_pipe #(.FRAC_BITS(FRAC_BITS)) u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_v    (pop),
    .in_item (head),
    .c_valid (c_valid),
    .c_long  (c_long),
    .c_item  (c_item),
    .c_sq    (c_sq),
    .c_res   (c_res)
  );

  vau_iter #(.FRAC_BITS(FRAC_BITS)) u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hand_off),
    .item  (c_item),
    .sq    (c_sq),
    .busy  (it_busy),
    .done  (it_done),
    .res   (it_res)
  );

  // Output register: the iterative unit finishes only while the pipeline is
  // held, so the two sources never load in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= short_ld || it_done;
    end
  end

  always_ff @(posedge clk) begin
    if (it_done) begin
      out_r <= it_res;
    end else if (short_ld) begin
      out_r <= c_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_r_x        = out_r.r_x;
  assign out_r_y        = out_r.r_y;
  assign out_r_z        = out_r.r_z;
  assign out_scalar_out = out_r.sc;
  assign out_flag       = out_r.flag;
  assign out_overflow   = out_r.ov;

endmodule
